// ----- rtl/core/mosr_pkg.sv -----
// Operation codes and types for the multi-op stream reduction unit.
package mosr_pkg;

    typedef logic [3:0] op_t;

    localparam op_t OP_MAX  = 4'd0;
    localparam op_t OP_MIN  = 4'd1;
    localparam op_t OP_SUM  = 4'd2;
    localparam op_t OP_PROD = 4'd3;
    localparam op_t OP_LAND = 4'd4;
    localparam op_t OP_BAND = 4'd5;
    localparam op_t OP_LOR  = 4'd6;
    localparam op_t OP_BOR  = 4'd7;
    localparam op_t OP_LXOR = 4'd8;
    localparam op_t OP_BXOR = 4'd9;

endpackage

// ----- rtl/core/multi_op_stream_reduction_unit.sv -----
// Top level of the multi-op stream reduction unit.
//
//  channel | direction | signals                          | payload
//  --------+-----------+----------------------------------+-------------------------------
//  s_      | in        | s_tvalid s_tready s_tdata s_tlast | cell_value, last_cell in tlast
//  m_      | out       | m_tvalid m_tready m_tdata         | reduced_value
//  cfg_    | in        | cfg_valid cfg_ready cfg_data      | operation
//
// One input transfer per cycle while s_tready is high; the accumulate op is combinational against acc_reg.
// A result appears on m_ in the cycle after the transfer carrying s_tlast.
// Reset clears the operation to max, the run state and the output valid.
// s_tready drops only while a result waits in the output register and m_tready is low.
// cfg_ready is always high; writes are to be made while the stream is idle; the block does not enforce it.
module multi_op_stream_reduction_unit #(
    parameter int DATA_WIDTH = 32,
    localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [TDATA_W-1:0]  s_tdata,   // cell_value
    input  logic                s_tlast,   // last_cell

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,   // reduced_value

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  mosr_pkg::op_t       cfg_data
);
    import mosr_pkg::*;

    localparam int LO_W = DATA_WIDTH / 2;
    localparam int HI_W = DATA_WIDTH - LO_W;

    op_t                   op_reg;
    logic [DATA_WIDTH-1:0] acc_reg;
    logic                  started_reg;
    logic [DATA_WIDTH-1:0] result_reg;
    logic                  out_valid_reg;

    logic [DATA_WIDTH-1:0] value;
    logic [DATA_WIDTH-1:0] prod;
    logic [DATA_WIDTH-1:0] combined;
    logic [DATA_WIDTH-1:0] acc_next;
    logic                  in_xfer;
    logic                  acc_nz;
    logic                  val_nz;

    assign value     = s_tdata[DATA_WIDTH-1:0];
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = TDATA_W'(result_reg);

    generate
        if (DATA_WIDTH <= 32) begin : g_mul_narrow
            assign prod = acc_reg * value;
        end else begin : g_mul_split
            logic [2*LO_W-1:0] p_ll;
            logic [HI_W-1:0]   p_lh;
            logic [HI_W-1:0]   p_hl;
            assign p_ll = acc_reg[LO_W-1:0] * value[LO_W-1:0];
            assign p_lh = HI_W'(acc_reg[LO_W-1:0]) * value[DATA_WIDTH-1:LO_W];
            assign p_hl = acc_reg[DATA_WIDTH-1:LO_W] * HI_W'(value[LO_W-1:0]);
            assign prod = DATA_WIDTH'(p_ll) + {HI_W'(p_lh + p_hl), {LO_W{1'b0}}};
        end
    endgenerate

    assign acc_nz = |acc_reg;
    assign val_nz = |value;

    always_comb
    begin
        unique case (op_reg)
            OP_MAX:  combined = ($signed(acc_reg) < $signed(value)) ? value : acc_reg;
            OP_MIN:  combined = ($signed(value) < $signed(acc_reg)) ? value : acc_reg;
            OP_SUM:  combined = acc_reg + value;
            OP_PROD: combined = prod;
            OP_LAND: combined = DATA_WIDTH'(acc_nz && val_nz);
            OP_BAND: combined = acc_reg & value;
            OP_LOR:  combined = DATA_WIDTH'(acc_nz || val_nz);
            OP_BOR:  combined = acc_reg | value;
            OP_LXOR: combined = DATA_WIDTH'(acc_nz != val_nz);
            OP_BXOR: combined = acc_reg ^ value;
            default: combined = acc_reg;
        endcase
    end

    assign acc_next = started_reg ? combined : value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= OP_MAX;
            acc_reg       <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                op_reg <= cfg_data;
            end
            if (in_xfer)
            begin
                acc_reg     <= acc_next;
                started_reg <= !s_tlast;
            end
            if (in_xfer && s_tlast)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && s_tlast)
        begin
            result_reg <= acc_next;
        end
    end

endmodule

// ----- rtl/core/mosr_checker.sv -----
// Port-level assertion checker for the multi-op stream reduction unit, with its bind.
module mosr_checker #(
    parameter int DATA_WIDTH = 32,
    localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8
) (
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               s_tlast,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("last transfer produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid && !(s_tvalid && s_tready && s_tlast) |=> !m_tvalid)
        else $error("result without a last transfer");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result stalled");

endmodule

bind multi_op_stream_reduction_unit mosr_checker #(.DATA_WIDTH(DATA_WIDTH)) u_mosr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- bench/tb_multi_op_stream_reduction_unit.sv -----
// Testbench for the multi-op stream reduction unit: directed and random runs, checked per result.
module tb_multi_op_stream_reduction_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import mosr_pkg::*;

    localparam op_t OP_FIRST_UNUSED = 4'd10;
    localparam op_t OP_LAST_CODE    = 4'd15;
    localparam int  DRAIN_CYCLES    = 4;
    localparam int  HOLD_CYCLES     = 150;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // cell_value
    logic        s_tlast   = 1'b0; // last_cell
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // reduced_value
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    op_t         cfg_data  = OP_MAX;

    logic [31:0] expected_reductions[$];
    op_t         op_q;
    logic [31:0] acc_q;
    bit          run_open;
    int unsigned mismatches   = 0;
    bit          gaps_on      = 1'b1;
    bit          sink_gaps_on = 1'b1;
    bit          hold_req     = 1'b0;

    multi_op_stream_reduction_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [31:0] fold_cell(op_t op, logic [31:0] acc, logic [31:0] v);
        case (op)
            OP_MAX:  return ($signed(acc) < $signed(v)) ? v : acc;
            OP_MIN:  return ($signed(v) < $signed(acc)) ? v : acc;
            OP_SUM:  return acc + v;
            OP_PROD: return acc * v;
            OP_LAND: return {31'b0, (acc != 0) && (v != 0)};
            OP_BAND: return acc & v;
            OP_LOR:  return {31'b0, (acc != 0) || (v != 0)};
            OP_BOR:  return acc | v;
            OP_LXOR: return {31'b0, (acc != 0) != (v != 0)};
            OP_BXOR: return acc ^ v;
            default: return acc;
        endcase
    endfunction

    function automatic int idle_len(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic logic [31:0] pick_cell();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'h8000_0000;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'hFFFF_FFFF;
            4:       return $urandom_range(0, 3);
            5:       return -$urandom_range(1, 4);
            default: return $urandom();
        endcase
    endfunction

    function automatic op_t pick_op();
        if ($urandom_range(0, 9) == 0)
            return op_t'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
        return op_t'($urandom_range(OP_MAX, OP_BXOR));
    endfunction

    function automatic int pick_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(7, 40);
        return $urandom_range(1, 6);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // model of the block, updated on every accepted transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_q     = OP_MAX;
            acc_q    = '0;
            run_open = 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                op_q = cfg_data;
            if (s_tvalid && s_tready)
            begin
                acc_q    = run_open ? fold_cell(op_q, acc_q, s_tdata) : s_tdata;
                run_open = !s_tlast;
                if (s_tlast)
                    expected_reductions.push_back(acc_q);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        logic [31:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_reductions.size() == 0)
                report_mismatch("unexpected result", m_tdata, 'x);
            else
            begin
                want = expected_reductions.pop_front();
                if (m_tdata !== want)
                    report_mismatch("reduced_value", m_tdata, want);
            end
        end
    end

    // receiver side: random stalls, plus one long hold-off on request
    initial
    begin : sink_ready
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = idle_len(sink_gaps_on);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_cell(input logic [31:0] value, input bit last);
        int gap;
        gap = idle_len(gaps_on);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // stop the stream and wait for every pending result
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_reductions.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_operation(op_t op);
        cfg_valid <= 1'b1;
        cfg_data  <= op;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic pair_run(op_t op, logic [31:0] a, logic [31:0] b);
        settle();
        write_operation(op);
        send_cell(a, 1'b0);
        send_cell(b, 1'b1);
    endtask

    task automatic test_directed();
        // reset operation is max
        send_cell(-5, 1'b0);
        send_cell(3, 1'b1);
        pair_run(OP_MAX,  32'h8000_0000, 32'h7FFF_FFFF);
        pair_run(OP_MIN,  32'h7FFF_FFFF, 32'h8000_0000);
        pair_run(OP_SUM,  32'h7FFF_FFFF, 32'h0000_0001);
        pair_run(OP_PROD, 32'h8000_0000, 32'hFFFF_FFFF);
        pair_run(OP_LAND, 32'h8000_0000, 32'h0000_0002);
        pair_run(OP_BAND, 32'hFFFF_FFFF, 32'h8000_0001);
        pair_run(OP_LOR,  32'h0000_0000, 32'h0000_0000);
        pair_run(OP_BOR,  32'h0000_0000, 32'hFFFF_FFFF);
        pair_run(OP_LXOR, 32'h0000_0001, 32'h8000_0000);
        pair_run(OP_BXOR, 32'hAAAA_AAAA, 32'h5555_5555);
        // single cell under a logical op is not normalized
        settle();
        write_operation(OP_LAND);
        send_cell(32'h8000_0000, 1'b1);
        pair_run(OP_LAST_CODE, 32'h1234_5678, 32'hFFFF_FFFF);
        // op switch in the middle of a run
        settle();
        write_operation(OP_SUM);
        send_cell(7, 1'b0);
        settle();
        write_operation(OP_PROD);
        send_cell(-3, 1'b1);
    endtask

    task automatic test_random_runs(int target);
        int sent;
        int len;
        sent = 0;
        while (sent < target)
        begin
            settle();
            write_operation(pick_op());
            gaps_on      = $urandom_range(0, 3) != 0;
            sink_gaps_on = $urandom_range(0, 3) != 0;
            repeat ($urandom_range(3, 10))
            begin
                len = pick_len();
                for (int i = 0; i < len; i++)
                begin
                    if (i > 0 && $urandom_range(0, 24) == 0)
                    begin
                        settle();
                        write_operation(pick_op());
                    end
                    send_cell(pick_cell(), i == len - 1);
                    sent++;
                end
            end
        end
    endtask

    // receiver holds off while the sender keeps pushing short runs
    task automatic test_output_stall();
        settle();
        write_operation(OP_SUM);
        gaps_on = 1'b0;
        hold_req = 1'b1;
        repeat (24)
            send_cell(pick_cell(), $urandom_range(0, 1));
        send_cell(pick_cell(), 1'b1);
        gaps_on = 1'b1;
        sink_gaps_on = 1'b1;
    endtask

    initial
    begin : main
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_runs(420);
        test_output_stall();
        test_random_runs(430);
        settle();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin : watchdog
        #2ms;
        $display("FAILURE");
        $finish;
    end

endmodule
